// ----- sv/telnet_vt_input_parser_fifo_core_assert.svh -----
// assertion macros shared by the parser fifo modules
`ifndef TELNET_VT_INPUT_PARSER_FIFO_CORE_ASSERT_SVH
`define TELNET_VT_INPUT_PARSER_FIFO_CORE_ASSERT_SVH

// same-cycle implication, checked on clk, quiet during reset
`define TVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, quiet during reset
`define TVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tvp_pkg.sv -----
// types, constants and byte tables of the telnet parser fifo
`default_nettype none
package tvp_pkg;

  // fifo geometry
  localparam int FIFO_DEPTH = 4096;
  localparam int IDX_W = $clog2(FIFO_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);

  // request kinds
  localparam logic [1:0] KIND_RX      = 2'd0;
  localparam logic [1:0] KIND_POP     = 2'd1;
  localparam logic [1:0] KIND_CONNECT = 2'd2;

  // telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // telnet options and qualifiers
  localparam logic [7:0] OPT_ECHO     = 8'd1;
  localparam logic [7:0] OPT_SGA      = 8'd3;
  localparam logic [7:0] OPT_TTYPE    = 8'd24;
  localparam logic [7:0] OPT_LINEMODE = 8'd34;
  localparam logic [7:0] QUAL_IS      = 8'd0;
  localparam logic [7:0] QUAL_SEND    = 8'd1;

  // terminal characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_GS     = 8'h1d;
  localparam logic [7:0] CH_REMOTE = 8'hb3;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;
  localparam logic [7:0] KEY_UP    = 8'd16;
  localparam logic [7:0] KEY_DOWN  = 8'd14;
  localparam logic [7:0] KEY_RIGHT = 8'd6;
  localparam logic [7:0] KEY_LEFT  = 8'd2;

  // reply sequence lengths, as last step index
  localparam logic [3:0] TTYPE_LAST = 4'd5;
  localparam logic [3:0] NEGO_LAST  = 4'd11;

  typedef enum logic [3:0] {
    PS_TEXT     = 4'd0,
    PS_VT1      = 4'd1,
    PS_VT2      = 4'd2,
    PS_REMOTE   = 4'd3,
    PS_TELNET   = 4'd4,
    PS_IYOU     = 4'd5,
    PS_SB1      = 4'd6,
    PS_SB2      = 4'd7,
    PS_SB_TTYPE = 4'd8,
    PS_NEXT     = 4'd9
  } parse_state_t;

  typedef enum logic [1:0] {
    TX_NONE  = 2'd0,
    TX_TTYPE = 2'd1,
    TX_NEGO  = 2'd2
  } tx_sel_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data;
    logic       empty_res;
    logic       last;
  } out_item_t;

  // work decoded for one request
  typedef struct packed {
    logic [1:0]      npu;
    logic [2:0][7:0] put_byte;
    tx_sel_t         tx_sel;
    logic            pop;
    logic            upd;
    parse_state_t    ns;
    logic            set_cmd;
    logic            set_opt;
  } plan_t;

  typedef struct packed {
    logic       put;
    logic [7:0] put_data;
    logic       pop;
  } fifo_req_t;

  // bytes of the two transmit sequences
  function automatic logic [7:0] tx_byte(tx_sel_t sel, logic [3:0] idx);
    logic [7:0] b;
    b = 8'd0;
    case (sel)
      TX_TTYPE: begin
        case (idx)
          4'd0: b = B_IAC;
          4'd1: b = B_SB;
          4'd2: b = OPT_TTYPE;
          4'd3: b = QUAL_SEND;
          4'd4: b = B_IAC;
          4'd5: b = B_SE;
          default: b = 8'd0;
        endcase
      end
      TX_NEGO: begin
        case (idx)
          4'd0:  b = B_IAC;
          4'd1:  b = B_DO;
          4'd2:  b = OPT_TTYPE;
          4'd3:  b = B_IAC;
          4'd4:  b = B_WILL;
          4'd5:  b = OPT_ECHO;
          4'd6:  b = B_IAC;
          4'd7:  b = B_WILL;
          4'd8:  b = OPT_SGA;
          4'd9:  b = B_IAC;
          4'd10: b = B_DONT;
          4'd11: b = OPT_LINEMODE;
          default: b = 8'd0;
        endcase
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- sv/telnet_vt_input_parser_fifo_core.sv -----
// Telnet/VT receive parser with character fifo, top level.
// A request is held in the input register while it runs; results leave via the result register.
// Throughput: one request per cycle for pops and plain bytes while the output is not stalled;
// escape replays (one fifo write port), TTYPE and connect go one byte per step, stalling input.
// Reset: rst synchronous, active high; pointers and parse state cleared, fifo memory is not
// cleared and needs no clearing pass.
`default_nettype none
`include "telnet_vt_input_parser_fifo_core_assert.svh"
module telnet_vt_input_parser_fifo_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tvp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tvp_pkg::out_item_t      out_data
);

  logic terminal_mode;
  tvp_pkg::in_item_t in_q;
  logic in_valid_q;
  logic [3:0] step;
  logic [3:0] last_step;
  tvp_pkg::plan_t plan;
  tvp_pkg::fifo_req_t fifo_req;
  logic fifo_empty;
  logic [7:0] fifo_rd_data;
  tvp_pkg::out_item_t res;
  logic res_valid;
  logic res_from_mem;
  logic emits;
  logic res_free;
  logic go;
  logic done;
  logic [7:0] put_sel;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_mode <= 1'b1;
    end else if (cfg_wen) begin
      terminal_mode <= cfg_wdata;
    end
  end

  tvp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .item   (in_q),
    .mode   (terminal_mode),
    .commit (done),
    .plan   (plan)
  );

  // step count and handshake of the working request
  always_comb begin
    if (plan.pop) begin
      last_step = 4'd0;
    end else if (plan.tx_sel == tvp_pkg::TX_TTYPE) begin
      last_step = tvp_pkg::TTYPE_LAST;
    end else if (plan.tx_sel == tvp_pkg::TX_NEGO) begin
      last_step = tvp_pkg::NEGO_LAST;
    end else if (plan.npu == 2'd0) begin
      last_step = 4'd0;
    end else begin
      last_step = {2'b00, plan.npu - 2'd1};
    end
  end

  assign emits = plan.pop || (plan.tx_sel != tvp_pkg::TX_NONE);
  assign res_free = !res_valid || out_ready;
  assign go = in_valid_q && (!emits || res_free);
  assign done = go && (step == last_step);
  assign in_ready = !in_valid_q || done;

  // byte written in this step of a replay
  always_comb begin
    case (step[1:0])
      2'd0: put_sel = plan.put_byte[0];
      2'd1: put_sel = plan.put_byte[1];
      2'd2: put_sel = plan.put_byte[2];
      default: put_sel = 8'd0;
    endcase
  end

  assign fifo_req.put = go && ({2'b00, plan.npu} > step);
  assign fifo_req.put_data = put_sel;
  assign fifo_req.pop = go && plan.pop;

  tvp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .req     (fifo_req),
    .empty   (fifo_empty),
    .rd_data (fifo_rd_data)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      step <= 4'd0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (done) begin
        in_valid_q <= 1'b0;
      end
      if (done) begin
        step <= 4'd0;
      end else if (go) begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go && emits) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emits) begin
      res.result_kind <= !plan.pop;
      res.data <= plan.pop ? 8'd0 : tvp_pkg::tx_byte(plan.tx_sel, step);
      res.empty_res <= plan.pop && fifo_empty;
      res.last <= done;
      res_from_mem <= plan.pop && !fifo_empty;
    end
  end

  assign out_valid = res_valid;
  assign out_data.result_kind = res.result_kind;
  assign out_data.data = res_from_mem ? fifo_rd_data : res.data;
  assign out_data.empty_res = res.empty_res;
  assign out_data.last = res.last;

  `TVP_ASSERT_IMP(a_empty_zero, out_valid && out_data.empty_res, out_data.data == 8'd0, "empty pop with data")
  `TVP_ASSERT_IMP(a_step_bound, in_valid_q, step <= last_step, "step past end of request")
  `TVP_ASSERT_IMP(a_pop_one_step, go && plan.pop, done, "pop did not finish in one step")

endmodule
`default_nettype wire

// ----- sv/tvp_parse.sv -----
// telnet and escape parser: decodes one request and holds the parse state
`default_nettype none
module tvp_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tvp_pkg::in_item_t item,
  input  wire logic             mode,
  input  wire logic             commit,
  output tvp_pkg::plan_t        plan
);

  tvp_pkg::parse_state_t parse_state;
  logic [7:0] saved_command;
  logic [7:0] saved_option;
  logic [7:0] c;

  assign c = item.rx_byte;

  // decode the work for the request in front
  always_comb begin
    plan = '0;
    plan.tx_sel = tvp_pkg::TX_NONE;
    plan.ns = parse_state;
    case (item.kind)
      tvp_pkg::KIND_RX: begin
        if (!mode) begin
          plan.npu = 2'd1;
          plan.put_byte[0] = c;
        end else begin
          plan.upd = 1'b1;
          plan.ns = tvp_pkg::PS_TEXT;
          case (parse_state)
            tvp_pkg::PS_VT1: begin
              if (c == tvp_pkg::CH_LBRK) begin
                plan.ns = tvp_pkg::PS_VT2;
              end else begin
                plan.npu = 2'd2;
                plan.put_byte[0] = tvp_pkg::CH_ESC;
                plan.put_byte[1] = c;
              end
            end
            tvp_pkg::PS_VT2: begin
              plan.npu = 2'd1;
              case (c)
                tvp_pkg::CH_UP:    plan.put_byte[0] = tvp_pkg::KEY_UP;
                tvp_pkg::CH_DOWN:  plan.put_byte[0] = tvp_pkg::KEY_DOWN;
                tvp_pkg::CH_RIGHT: plan.put_byte[0] = tvp_pkg::KEY_RIGHT;
                tvp_pkg::CH_LEFT:  plan.put_byte[0] = tvp_pkg::KEY_LEFT;
                default: begin
                  // unknown escape replayed as typed
                  plan.npu = 2'd3;
                  plan.put_byte[0] = tvp_pkg::CH_ESC;
                  plan.put_byte[1] = tvp_pkg::CH_LBRK;
                  plan.put_byte[2] = c;
                end
              endcase
            end
            tvp_pkg::PS_REMOTE: begin
              plan.ns = tvp_pkg::PS_TEXT;
            end
            tvp_pkg::PS_TELNET: begin
              plan.set_cmd = 1'b1;
              if (c inside {tvp_pkg::B_WILL, tvp_pkg::B_WONT, tvp_pkg::B_DO,
                            tvp_pkg::B_DONT}) begin
                plan.ns = tvp_pkg::PS_IYOU;
              end else if (c == tvp_pkg::B_SB) begin
                plan.ns = tvp_pkg::PS_SB1;
              end else if (c == tvp_pkg::B_IAC) begin
                plan.npu = 2'd1;
                plan.put_byte[0] = tvp_pkg::B_IAC;
              end
            end
            tvp_pkg::PS_IYOU: begin
              plan.set_opt = 1'b1;
              if (saved_command == tvp_pkg::B_WILL && c == tvp_pkg::OPT_TTYPE) begin
                plan.tx_sel = tvp_pkg::TX_TTYPE;
              end
            end
            tvp_pkg::PS_SB1: begin
              plan.set_opt = 1'b1;
              plan.ns = tvp_pkg::PS_SB2;
            end
            tvp_pkg::PS_SB2: begin
              if (saved_option == tvp_pkg::OPT_TTYPE && c == tvp_pkg::QUAL_IS) begin
                plan.ns = tvp_pkg::PS_SB_TTYPE;
              end else begin
                plan.ns = tvp_pkg::PS_NEXT;
              end
            end
            tvp_pkg::PS_SB_TTYPE: begin
              plan.ns = tvp_pkg::PS_NEXT;
            end
            tvp_pkg::PS_NEXT: begin
              plan.ns = (c == tvp_pkg::B_IAC) ? tvp_pkg::PS_TELNET : tvp_pkg::PS_NEXT;
            end
            default: begin
              // text state and any stray code
              if (c == tvp_pkg::CH_ESC) begin
                plan.ns = tvp_pkg::PS_VT1;
              end else if (c inside {tvp_pkg::CH_GS, tvp_pkg::CH_REMOTE}) begin
                plan.ns = tvp_pkg::PS_REMOTE;
              end else if (c == tvp_pkg::B_IAC) begin
                plan.ns = tvp_pkg::PS_TELNET;
              end else if (c != tvp_pkg::CH_NUL && c != tvp_pkg::CH_LF) begin
                plan.npu = 2'd1;
                plan.put_byte[0] = c;
              end
            end
          endcase
        end
      end
      tvp_pkg::KIND_POP: begin
        plan.pop = 1'b1;
      end
      tvp_pkg::KIND_CONNECT: begin
        if (mode) begin
          plan.tx_sel = tvp_pkg::TX_NEGO;
          plan.upd = 1'b1;
          plan.ns = tvp_pkg::PS_TELNET;
        end
      end
      default: begin
        plan.upd = 1'b0;
      end
    endcase
  end

  // parse state moves when the request finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= tvp_pkg::PS_TEXT;
      saved_command <= 8'd0;
      saved_option <= 8'd0;
    end else if (commit) begin
      if (plan.upd) begin
        parse_state <= plan.ns;
      end
      if (plan.set_cmd) begin
        saved_command <= c;
      end
      if (plan.set_opt) begin
        saved_option <= c;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/tvp_fifo.sv -----
// ring fifo of received characters, one slot kept free
`default_nettype none
`include "telnet_vt_input_parser_fifo_core_assert.svh"
module tvp_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tvp_pkg::fifo_req_t req,
  output logic                    empty,
  output logic [7:0]              rd_data
);

  logic [7:0] char_store [tvp_pkg::FIFO_DEPTH];
  logic [tvp_pkg::IDX_W-1:0] write_index;
  logic [tvp_pkg::IDX_W-1:0] read_index;
  logic [tvp_pkg::IDX_W-1:0] write_inc;
  logic [tvp_pkg::IDX_W-1:0] read_inc;
  logic full;

  // wrapped index arithmetic
  assign write_inc = (write_index == tvp_pkg::IDX_LAST) ? '0 : write_index + 1'b1;
  assign read_inc  = (read_index == tvp_pkg::IDX_LAST) ? '0 : read_index + 1'b1;
  assign full  = (write_inc == read_index);
  assign empty = (write_index == read_index);

  // storage, registered read
  always_ff @(posedge clk) begin
    if (req.put && !full) begin
      char_store[write_index] <= req.put_data;
    end
    if (req.pop && !empty) begin
      rd_data <= char_store[read_index];
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index <= '0;
    end else begin
      if (req.put && !full) begin
        write_index <= write_inc;
      end
      if (req.pop && !empty) begin
        read_index <= read_inc;
      end
    end
  end

  `TVP_ASSERT_IMP(a_no_put_with_pop, req.put, !req.pop, "fifo put and pop together")
  `TVP_ASSERT_NXT(a_full_drops, req.put && full, $stable(write_index), "put advanced full fifo")
  `TVP_ASSERT_NXT(a_empty_holds, req.pop && empty, $stable(read_index), "pop advanced empty fifo")

endmodule
`default_nettype wire
